// ----- design/ise_pkg.sv -----
// ise_pkg: shared types and constants for the indexed stack engine.
// Used by ise_cell, ise_ctrl and indexed_stack_engine; no dependencies.
`timescale 1ns / 1ps

package ise_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 8;
	localparam int ACT_W  = 3;
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 48;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 3'd0,
		ACT_POP     = 3'd1,
		ACT_PEEK    = 3'd2,
		ACT_FIND    = 3'd3,
		ACT_REVERSE = 3'd4,
		ACT_CLEAR   = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_LOAD_TAG,
		CMD_SWAP_EVEN,
		CMD_SWAP_ODD
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REV
	} state_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [IDX_W-1:0]   slot;
		logic [CNT_W-1:0]   count;
		logic [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

// ----- design/indexed_stack_engine.sv -----
// indexed_stack_engine: top level; a chain of DEPTH cells with one controller.
// Transaction: accepted in idle, then one cell-chain update in execution, which also loads the result.
// Reverse: load tags, count odd-even swap rounds, then the result.
// Transactions: a new one is accepted only in idle; a waiting result holds the next one in execution.
// Reset: arst_n clears the fill count and control; entries are not cleared.
`timescale 1ns / 1ps

module indexed_stack_engine import ise_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // action[2:0], position[10:3], item_value[42:11]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // ok[0], read_value[32:1], found[33], count[40:34]
);

	cell_ctl_t         ctl;
	logic [DATA_W-1:0] entry [DEPTH];
	logic [IDX_W-1:0]  tag   [DEPTH];
	logic [DATA_W-1:0] rd    [DEPTH];
	logic [DEPTH-1:0]  hit;
	logic              found_any;
	logic [DATA_W-1:0] rd_any;
	logic              ok;
	logic [DATA_W-1:0] read_value;
	logic              found;
	logic [CNT_W-1:0]  count;

	ise_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_action   (s_tdata[2:0]),
		.in_position (s_tdata[10:3]),
		.in_value    (s_tdata[42:11]),
		.found_any   (found_any),
		.rd_any      (rd_any),
		.ctl         (ctl),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_ok      (ok),
		.out_read    (read_value),
		.out_found   (found),
		.out_count   (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] lo_e, hi_e;
		logic [IDX_W-1:0]  lo_t, hi_t;
		if (i == 0) begin : g_bot
			assign lo_e = '0;
			assign lo_t = '0;
		end else begin : g_lo
			assign lo_e = entry[i-1];
			assign lo_t = tag[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign hi_e = '0;
			assign hi_t = '0;
		end else begin : g_hi
			assign hi_e = entry[i+1];
			assign hi_t = tag[i+1];
		end
		ise_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.ctl      (ctl),
			.lo_entry (lo_e),
			.lo_tag   (lo_t),
			.hi_entry (hi_e),
			.hi_tag   (hi_t),
			.entry    (entry[i]),
			.tag      (tag[i]),
			.hit      (hit[i]),
			.rd       (rd[i])
		);
	end

	assign found_any = |hit;

	always_comb begin
		rd_any = '0;
		for (int j = 0; j < DEPTH; j++) begin
			rd_any = rd_any | rd[j];
		end
	end

	assign m_tdata = {(OUT_W - 41)'(0), count, found, read_value, ok};

endmodule

// ----- design/ise_cell.sv -----
// ise_cell: one stack slot of the cell chain; holds an entry and a sort tag.
// Takes data from its lower and upper neighbors. Depends on ise_pkg.
`timescale 1ns / 1ps

module ise_cell import ise_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] lo_entry,
	input  logic [IDX_W-1:0]  lo_tag,
	input  logic [DATA_W-1:0] hi_entry,
	input  logic [IDX_W-1:0]  hi_tag,
	output logic [DATA_W-1:0] entry,
	output logic [IDX_W-1:0]  tag,
	output logic              hit,
	output logic [DATA_W-1:0] rd
);

	logic [DATA_W-1:0] entry_q;
	logic [IDX_W-1:0]  tag_q;
	logic [CNT_W-1:0]  idx_c;
	logic              live;
	logic              next_live;
	logic              is_lower;
	logic              swap_up;
	logic              swap_dn;
	logic              parity;

	assign idx_c     = CNT_W'(idx);
	assign live      = idx_c < ctl.count;
	assign next_live = (idx_c + CNT_W'(1)) < ctl.count;
	assign parity    = (ctl.cmd == CMD_SWAP_ODD);
	assign is_lower  = (idx[0] == parity);
	// pair with upper neighbor: swap when upper tag is larger
	assign swap_up   = is_lower && next_live && (tag_q < hi_tag);
	// pair with lower neighbor
	assign swap_dn   = !is_lower && (idx != '0) && live && (lo_tag < tag_q);

	assign entry = entry_q;
	assign tag   = tag_q;
	assign hit   = live && (entry_q == ctl.value);
	assign rd    = (idx == ctl.slot) ? entry_q : '0;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (idx == ctl.slot) begin
					entry_q <= ctl.value;
				end else if (idx > ctl.slot && idx_c <= ctl.count) begin
					entry_q <= lo_entry;
				end
			end
			CMD_REMOVE: begin
				if (idx >= ctl.slot && next_live) begin
					entry_q <= hi_entry;
				end
			end
			CMD_LOAD_TAG: begin
				tag_q <= idx;
			end
			CMD_SWAP_EVEN, CMD_SWAP_ODD: begin
				if (swap_up) begin
					entry_q <= hi_entry;
					tag_q   <= hi_tag;
				end else if (swap_dn) begin
					entry_q <= lo_entry;
					tag_q   <= lo_tag;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/ise_ctrl.sv -----
// ise_ctrl: request decode, state machine, fill count and result register.
// Drives the broadcast control of the cell chain. Depends on ise_pkg.
`timescale 1ns / 1ps

module ise_ctrl import ise_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  in_action,
	input  logic [POS_W-1:0]  in_position,
	input  logic [DATA_W-1:0] in_value,
	input  logic              found_any,
	input  logic [DATA_W-1:0] rd_any,
	output cell_ctl_t         ctl,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_ok,
	output logic [DATA_W-1:0] out_read,
	output logic              out_found,
	output logic [CNT_W-1:0]  out_count
);

	state_t            state_q, state_d;
	logic [ACT_W-1:0]  op_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  round_q, round_d;
	logic              out_valid_q;
	logic              ok_q, found_q;
	logic [DATA_W-1:0] read_q;
	logic [CNT_W-1:0]  ocount_q;

	logic              load_out;
	logic              ok_d, found_d;
	logic [DATA_W-1:0] read_d;
	logic              fire_out;
	logic              pos_neg;
	logic [POS_W-1:0]  mag;
	logic [CMP_W-1:0]  mag_c, cnt_c;
	logic              push_ok, read_ok;
	logic [CMP_W-1:0]  push_slot, read_slot;
	logic              in_fire;

	assign in_fire  = in_valid && in_ready;
	assign fire_out = !out_valid_q || out_ready;
	assign pos_neg  = pos_q[POS_W-1];
	assign mag      = pos_neg ? (POS_W'(0) - pos_q) : pos_q;
	assign mag_c    = CMP_W'(mag);
	assign cnt_c    = CMP_W'(count_q);
	assign push_ok  = (count_q < CNT_W'(DEPTH)) && (mag_c <= cnt_c);
	assign read_ok  = mag_c < cnt_c;
	assign push_slot = pos_neg ? mag_c : (cnt_c - mag_c);
	assign read_slot = pos_neg ? mag_c : (cnt_c - CMP_W'(1) - mag_c);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (op_q == ACT_REVERSE && count_q != '0) begin
					state_d = ST_REV;
				end else if (fire_out) begin
					state_d = ST_IDLE;
				end
			end
			ST_REV: begin
				if (round_q >= count_q && fire_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and cell control
	always_comb begin
		ctl.cmd   = CMD_HOLD;
		ctl.slot  = '0;
		ctl.count = count_q;
		ctl.value = val_q;
		count_d   = count_q;
		round_d   = round_q;
		load_out  = 1'b0;
		ok_d      = 1'b0;
		found_d   = 1'b0;
		read_d    = '0;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_EXEC: begin
				if (op_q == ACT_REVERSE && count_q != '0) begin
					ctl.cmd = CMD_LOAD_TAG;
					round_d = '0;
				end else if (fire_out) begin
					load_out = 1'b1;
					case (op_q)
						ACT_PUSH: begin
							if (push_ok) begin
								ctl.cmd  = CMD_INSERT;
								ctl.slot = push_slot[IDX_W-1:0];
								count_d  = count_q + CNT_W'(1);
								ok_d     = 1'b1;
							end
						end
						ACT_POP, ACT_PEEK: begin
							ctl.slot = read_slot[IDX_W-1:0];
							if (read_ok) begin
								ok_d   = 1'b1;
								read_d = rd_any;
								if (op_q == ACT_POP) begin
									ctl.cmd = CMD_REMOVE;
									count_d = count_q - CNT_W'(1);
								end
							end
						end
						ACT_FIND: begin
							ok_d    = 1'b1;
							found_d = found_any;
						end
						ACT_CLEAR: begin
							ok_d    = 1'b1;
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_REV: begin
				if (round_q < count_q) begin
					ctl.cmd = round_q[0] ? CMD_SWAP_ODD : CMD_SWAP_EVEN;
					round_d = round_q + CNT_W'(1);
				end else if (fire_out) begin
					load_out = 1'b1;
					ok_d     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			round_q <= round_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= in_action;
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (load_out) begin
			ok_q     <= ok_d;
			found_q  <= found_d;
			read_q   <= read_d;
			ocount_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ok    = ok_q;
	assign out_read  = read_q;
	assign out_found = found_q;
	assign out_count = ocount_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_rev_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REV |=> count_q == $past(count_q))
		else $error("count changed during reverse");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REV |-> round_q <= count_q)
		else $error("reverse round past count");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_EXEC)
		else $error("accepted transaction not executed");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> state_q != ST_IDLE)
		else $error("result loaded while idle");

endmodule
